### rtl/core/rgbmp_pkg.sv
// Shared types, constants and register codes for the RGB565 to monochrome page packer.
`default_nettype none
package rgbmp_pkg;

	localparam int PANEL_COLUMNS_DEF = 128;
	localparam int MAX_ROWS_DEF      = 64;

	localparam int PAGE_ROWS = 8;
	localparam int ROW_W     = 6;
	localparam int PAGE_W    = 3;
	localparam int SUB_W     = 3;
	localparam int CFG_W     = 6;
	localparam int REG_IDX_W = 2;

	localparam logic [SUB_W-1:0] FIRST_SUB = SUB_W'(0);
	localparam logic [SUB_W-1:0] LAST_SUB  = SUB_W'(PAGE_ROWS - 1);

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_RED   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_GREEN = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BLUE  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_TALL  = 2'd3;

	localparam logic [4:0] RED_RESET   = 5'd6;
	localparam logic [5:0] GREEN_RESET = 6'd12;
	localparam logic [4:0] BLUE_RESET  = 5'd6;
	localparam logic       TALL_RESET  = 1'b1;

	typedef struct packed {
		logic [15:0] pixel;
		logic        forget_previous;
	} pixel_t;

	typedef struct packed {
		logic [7:0] page_byte;
		logic [6:0] column;
		logic [2:0] page_index;
		logic       byte_differs;
		logic       frame_done;
		logic       frame_differs;
	} result_t;

	typedef struct packed {
		logic [4:0] red_threshold;
		logic [5:0] green_threshold;
		logic [4:0] blue_threshold;
		logic       tall_panel;
	} cfg_t;

	// Per-pixel control handed from the scan counters to the page store.
	typedef struct packed {
		logic             lit;
		logic             forget;
		logic [SUB_W-1:0] sub;
		logic             frame_end;
	} ctl_t;

endpackage
`default_nettype wire

### rtl/core/rgb565_to_mono_page_packer.sv
// Top level of the RGB565 to monochrome page packer: configuration registers and channel wiring.
`default_nettype none
// Takes one RGB565 pixel per clock in raster order and returns a packed page byte
// (eight vertical pixels, bit n for row n of the page) for every pixel on the last
// row of a page, together with its column, its page and whether it differs from the
// byte stored for that place in the previous frame. The final byte of a frame also
// reports whether any byte of the frame differed. Throughput is one pixel transfer
// per clock while the output is not stalled. The transfer of a byte's last pixel
// loads the registered read of the accumulator and previous-frame memories, and
// the read-modify-write stage then loads the finished byte into the output
// register. While a byte waits at the output, the read stage holds the next pixel and
// the pixel input stalls. Both memories need no clearing after reset, so pixels are
// taken from the first cycle. Thresholds and the panel height should be written only
// while no pixel is in flight.
module rgb565_to_mono_page_packer #(
	parameter int PANEL_COLUMNS = rgbmp_pkg::PANEL_COLUMNS_DEF,
	parameter int MAX_ROWS = rgbmp_pkg::MAX_ROWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pix_valid,
	output logic                            pix_ready,
	input  rgbmp_pkg::pixel_t               pix_data,
	output logic                            byte_valid,
	input  logic                            byte_ready,
	output rgbmp_pkg::result_t              byte_data,
	input  logic                            cfg_we,
	input  logic [rgbmp_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [rgbmp_pkg::CFG_W-1:0]     cfg_data
);

	localparam int Pages = MAX_ROWS / rgbmp_pkg::PAGE_ROWS;

	rgbmp_pkg::cfg_t              cfg_q;
	rgbmp_pkg::ctl_t              ctl;
	logic [$clog2(PANEL_COLUMNS)-1:0] col;
	logic [rgbmp_pkg::PAGE_W-1:0] page;
	logic                         take;

	assign take = pix_valid && pix_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_threshold   <= rgbmp_pkg::RED_RESET;
			cfg_q.green_threshold <= rgbmp_pkg::GREEN_RESET;
			cfg_q.blue_threshold  <= rgbmp_pkg::BLUE_RESET;
			cfg_q.tall_panel      <= rgbmp_pkg::TALL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rgbmp_pkg::REG_RED: begin
					cfg_q.red_threshold <= cfg_data[4:0];
				end
				rgbmp_pkg::REG_GREEN: begin
					cfg_q.green_threshold <= cfg_data[5:0];
				end
				rgbmp_pkg::REG_BLUE: begin
					cfg_q.blue_threshold <= cfg_data[4:0];
				end
				rgbmp_pkg::REG_TALL: begin
					cfg_q.tall_panel <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	rgbmp_scan #(
		.Cols(PANEL_COLUMNS),
		.MaxRows(MAX_ROWS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.pix(pix_data),
		.cfg(cfg_q),
		.ctl(ctl),
		.col(col),
		.page(page)
	);

	rgbmp_page_store #(
		.Cols(PANEL_COLUMNS),
		.Pages(Pages)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.ctl(ctl),
		.col(col),
		.page(page),
		.ready(pix_ready),
		.out_valid(byte_valid),
		.out_ready(byte_ready),
		.out_data(byte_data)
	);

endmodule
`default_nettype wire

### rtl/core/rgbmp_scan.sv
// Raster position counters and pixel threshold test.
`default_nettype none
module rgbmp_scan #(
	parameter int Cols = rgbmp_pkg::PANEL_COLUMNS_DEF,
	parameter int MaxRows = rgbmp_pkg::MAX_ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  rgbmp_pkg::pixel_t           pix,
	input  rgbmp_pkg::cfg_t             cfg,
	output rgbmp_pkg::ctl_t             ctl,
	output logic [$clog2(Cols)-1:0]     col,
	output logic [rgbmp_pkg::PAGE_W-1:0] page
);

	localparam int ColW      = $clog2(Cols);
	localparam int TallRows  = (MaxRows / rgbmp_pkg::PAGE_ROWS) * rgbmp_pkg::PAGE_ROWS;
	localparam int LowRaw    = (TallRows / 2 / rgbmp_pkg::PAGE_ROWS) * rgbmp_pkg::PAGE_ROWS;
	localparam int LowRows   = (LowRaw == 0) ? rgbmp_pkg::PAGE_ROWS : LowRaw;

	logic [ColW-1:0]             col_q;
	logic [rgbmp_pkg::ROW_W-1:0] row_q;
	logic [rgbmp_pkg::ROW_W-1:0] row_last;
	logic                        col_last;

	assign row_last = cfg.tall_panel ? rgbmp_pkg::ROW_W'(TallRows - 1)
	                                 : rgbmp_pkg::ROW_W'(LowRows - 1);
	assign col_last = (col_q == ColW'(Cols - 1));

	assign col  = col_q;
	assign page = row_q[rgbmp_pkg::ROW_W-1:rgbmp_pkg::SUB_W];

	always_comb begin
		ctl.lit = (pix.pixel[15:11] >= cfg.red_threshold) ||
		          (pix.pixel[10:5] >= cfg.green_threshold) ||
		          (pix.pixel[4:0] >= cfg.blue_threshold);
		ctl.forget    = pix.forget_previous;
		ctl.sub       = row_q[rgbmp_pkg::SUB_W-1:0];
		ctl.frame_end = (row_q == row_last) && col_last;
	end

	// A row count left beyond a shortened frame wraps at the end of its row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= (row_q >= row_last) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/rgbmp_page_store.sv
// Page accumulator and previous-frame memories with the read-modify-write stage and output register.
`default_nettype none
module rgbmp_page_store #(
	parameter int Cols = rgbmp_pkg::PANEL_COLUMNS_DEF,
	parameter int Pages = rgbmp_pkg::MAX_ROWS_DEF / rgbmp_pkg::PAGE_ROWS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  rgbmp_pkg::ctl_t              ctl,
	input  logic [$clog2(Cols)-1:0]      col,
	input  logic [rgbmp_pkg::PAGE_W-1:0] page,
	output logic                         ready,
	output logic                         out_valid,
	input  logic                         out_ready,
	output rgbmp_pkg::result_t           out_data
);

	localparam int ColW  = $clog2(Cols);
	localparam int Depth = Cols * Pages;
	localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int PageW = (Pages > 1) ? $clog2(Pages) : 1;

	logic [7:0] acc_mem  [Cols];
	logic [7:0] prev_mem [Depth];

	logic [IdxW-1:0] rd_idx;

	logic                         valid_s1;
	rgbmp_pkg::ctl_t              ctl_s1;
	logic [ColW-1:0]              col_s1;
	logic [rgbmp_pkg::PAGE_W-1:0] page_s1;
	logic [IdxW-1:0]              idx_s1;
	logic [7:0]                   acc_rd_q;
	logic [7:0]                   prev_rd_q;

	logic               known_q;
	logic               any_q;
	logic               out_valid_q;
	rgbmp_pkg::result_t out_q;

	logic       s1_go;
	logic       emit;
	logic       done;
	logic       known_eff;
	logic       differs;
	logic [7:0] bit_mask;
	logic [7:0] byte_new;

	assign rd_idx = IdxW'(IdxW'(page[PageW-1:0]) * IdxW'(Cols) + IdxW'(col));

	assign s1_go = valid_s1 && (!out_valid_q || out_ready);
	assign ready = !valid_s1 || s1_go;

	always_comb begin
		bit_mask  = ctl_s1.lit ? (8'd1 << ctl_s1.sub) : 8'd0;
		byte_new  = ((ctl_s1.sub == rgbmp_pkg::FIRST_SUB) ? 8'd0 : acc_rd_q) | bit_mask;
		emit      = (ctl_s1.sub == rgbmp_pkg::LAST_SUB);
		done      = emit && ctl_s1.frame_end;
		known_eff = known_q && !ctl_s1.forget;
		differs   = !known_eff || (prev_rd_q != byte_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			known_q     <= 1'b0;
			any_q       <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (s1_go) begin
				known_q <= done ? 1'b1 : known_eff;
				if (done) begin
					any_q <= 1'b0;
				end else if (emit && differs) begin
					any_q <= 1'b1;
				end
			end
		end
	end

	// Reads for a column and its page entry are issued on the transfer; the same
	// entries are not revisited until a whole row has passed, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (take) begin
			ctl_s1    <= ctl;
			col_s1    <= col;
			page_s1   <= page;
			idx_s1    <= rd_idx;
			acc_rd_q  <= acc_mem[col];
			prev_rd_q <= prev_mem[rd_idx];
		end
		if (s1_go) begin
			acc_mem[col_s1] <= byte_new;
			if (emit) begin
				prev_mem[idx_s1]    <= byte_new;
				out_q.page_byte     <= byte_new;
				out_q.column        <= 7'(col_s1);
				out_q.page_index    <= page_s1;
				out_q.byte_differs  <= differs;
				out_q.frame_done    <= done;
				out_q.frame_differs <= done && (any_q || differs);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_done_last_column: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.frame_done |-> out_q.column == 7'(Cols - 1))
		else $error("frame end reported away from the last column");

	a_frame_differs_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.frame_differs |-> out_q.frame_done)
		else $error("frame difference flagged on a byte that does not end the frame");

	a_unknown_previous_differs: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && emit && !known_eff |=> out_valid_q && out_q.byte_differs)
		else $error("byte not marked differing while the previous frame is unknown");

	a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_go |=> valid_s1 && $stable(col_s1) && $stable(idx_s1))
		else $error("stalled read-modify-write stage lost its entry");

endmodule
`default_nettype wire
